@@ hw/rtl/srg_pkg.sv @@
// Shared types and constants for the stepped run generator.
// Used by srg_ctrl, srg_datapath and stepped_run_generator_unit; no dependencies.
package srg_pkg;

    localparam int MAX_RUN = 64;
    localparam int COUNT_W = $clog2(MAX_RUN + 1);
    localparam int VAL_W   = 32;
    localparam int STEP_W  = 31;
    // Run walker: value plus or minus a step never leaves 34 signed bits
    localparam int ACC_W   = VAL_W + 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_START_VALUE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE   = 1'b1;

    typedef enum logic [1:0] {
        OP_SET_END   = 2'd0,
        OP_LIST_ELEM = 2'd1,
        OP_BANG      = 2'd2,
        OP_REWIND    = 2'd3
    } t_opcode;

    typedef struct packed {
        logic take;       // latch operand as target, load walker
        logic src_prior;  // walker starts at prior breakpoint, else start value
        logic mark;       // run_end flag for the final result of this item
        logic set_prior;
        logic clr_count;
        logic list_set;
        logic list_clr;
        logic bang;
        logic rewind;
        logic emit_run;
        logic emit_tail;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic list_open;
        logic count_gt1;
        logic at_cap;
        logic run_go;
        logic eq_prior;
        logic hold_valid;
        logic out_free;
    } t_status;

endpackage

@@ hw/rtl/stepped_run_generator_unit.sv @@
// Top level of the stepped run generator: ports, controller and datapath.
// Depends on srg_pkg, srg_ctrl and srg_datapath.
//
// Usage:
//  - Input stream s_*: one item per transfer. s_tuser carries the opcode
//    (set_end, list_element, bang, rewind), s_tdata the operand and s_tlast
//    marks the final breakpoint of a list.
//  - Output stream m_*: one run value per transfer; m_tlast flags the last
//    value of a set_end run, of a bang result and of a closing list step.
//  - Config port: i_cfg_we with i_cfg_index 0 writes start_value, index 1
//    writes step_size (zero is taken as one). Write only while idle.
//  - Throughput: the run walker (one add and one compare) yields one value
//    per cycle while the output register is free. s_tready stays low while
//    an item's results are walked and flushed; a non-final first breakpoint,
//    a rewind or a short-history bang leaves it high.
//  - Path: a bang result is written to the hold register and then to the
//    output register; a run value leaves the walker register the same way.
//  - Each value waits in a hold register so that the run_end flag can be
//    set on the truly last one.
//  - Stall: when m_tready is low the walker holds; nothing is dropped.
//    The next item is taken as soon as the final result sits in the
//    output register, even while that result is still stalled.
//  - Reset (synchronous, i_rst_n low): history and control registers return
//    to their defaults, payload registers are not reset; no clearing pass.
module stepped_run_generator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] operand
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    input  logic        s_tlast,   // final_element
    // result item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] run_value
    output logic        m_tlast,   // run_end
    // configuration writes
    input  logic                          i_cfg_we,
    input  logic [srg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_wdata
);

    srg_pkg::t_cmd    w_cmd;
    srg_pkg::t_status w_st;

    // sequence each item: decode, then walk the run, append and flush with run_end as its opcode needs
    srg_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_tvalid),
        .i_opcode (srg_pkg::t_opcode'(s_tuser)),
        .i_final  (s_tlast),
        .i_st     (w_st),
        .o_ready  (s_tready),
        .o_cmd    (w_cmd)
    );

    // walker, history and the hold/output pair
    srg_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_operand   (s_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_m_ready   (m_tready),
        .o_st        (w_st),
        .o_m_valid   (m_tvalid),
        .o_m_value   (m_tdata),
        .o_m_end     (m_tlast)
    );

endmodule

@@ hw/rtl/srg_ctrl.sv @@
// Sequencing state machine for the stepped run generator.
// Depends on srg_pkg; drives srg_datapath through t_cmd and reads t_status.
module srg_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  srg_pkg::t_opcode i_opcode,
    input  logic             i_final,
    input  srg_pkg::t_status i_st,
    output logic             o_ready,
    output srg_pkg::t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_TAIL,
        S_FLUSH
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_tails, n_tails;
    logic       w_slot_ok;

    // emitting pushes the held result out, so the output register must be free
    assign w_slot_ok = !i_st.hold_valid || i_st.out_free;
    assign o_ready   = (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_tails = r_tails;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    unique case (i_opcode)
                        srg_pkg::OP_SET_END: begin
                            o_cmd.mark      = 1'b1;
                            o_cmd.list_clr  = 1'b1;
                            o_cmd.clr_count = 1'b1;
                            n_tails         = 2'd1;
                            n_state         = S_RUN;
                        end
                        srg_pkg::OP_LIST_ELEM: begin
                            o_cmd.mark      = i_final;
                            o_cmd.set_prior = 1'b1;
                            o_cmd.list_clr  = i_final;
                            if (!i_st.list_open) begin
                                o_cmd.clr_count = 1'b1;
                                o_cmd.list_set  = !i_final;
                                if (i_final) begin
                                    n_tails = 2'd1;
                                    n_state = S_TAIL;
                                end
                            end else if (i_st.eq_prior) begin
                                n_tails = i_final ? 2'd2 : 2'd1;
                                n_state = S_TAIL;
                            end else begin
                                o_cmd.src_prior = 1'b1;
                                n_tails         = i_final ? 2'd1 : 2'd0;
                                n_state         = S_RUN;
                            end
                        end
                        srg_pkg::OP_BANG: begin
                            o_cmd.mark     = 1'b1;
                            o_cmd.list_clr = 1'b1;
                            if (i_st.count_gt1) begin
                                o_cmd.bang = 1'b1;
                                n_state    = S_FLUSH;
                            end
                        end
                        srg_pkg::OP_REWIND: begin
                            o_cmd.list_clr = 1'b1;
                            o_cmd.rewind   = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_RUN: begin
                if (i_st.run_go) begin
                    if (w_slot_ok) begin
                        o_cmd.emit_run = 1'b1;
                    end
                end else if (r_tails != 2'd0) begin
                    n_state = S_TAIL;
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_TAIL: begin
                if (r_tails == 2'd0 || i_st.at_cap) begin
                    n_state = S_FLUSH;
                end else if (w_slot_ok) begin
                    o_cmd.emit_tail = 1'b1;
                    n_tails         = r_tails - 2'd1;
                    if (r_tails == 2'd1) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (!i_st.hold_valid) begin
                    n_state = S_IDLE;
                end else if (i_st.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tails <= 2'd0;
        end else begin
            r_state <= n_state;
            r_tails <= n_tails;
        end
    end

endmodule

@@ hw/rtl/srg_datapath.sv @@
// Run walker, output history, hold and output registers, and config registers.
// Depends on srg_pkg; commanded by srg_ctrl.
module srg_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  srg_pkg::t_cmd               i_cmd,
    input  logic [srg_pkg::VAL_W-1:0]   i_operand,
    input  logic                        i_cfg_we,
    input  logic [srg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [srg_pkg::VAL_W-1:0]   i_cfg_wdata,
    input  logic                        i_m_ready,
    output srg_pkg::t_status            o_st,
    output logic                        o_m_valid,
    output logic [srg_pkg::VAL_W-1:0]   o_m_value,
    output logic                        o_m_end
);

    localparam int VW = srg_pkg::VAL_W;
    localparam int AW = srg_pkg::ACC_W;
    localparam int CW = srg_pkg::COUNT_W;
    localparam int SW = srg_pkg::STEP_W;

    logic signed [VW-1:0] r_start, r_latest, r_prev, r_prior, r_b;
    logic [VW-1:0]        r_nc, r_hold;
    logic [SW-1:0]        r_step;
    logic signed [AW-1:0] r_j;
    logic                 r_up, r_mark, r_list_open, r_hold_valid;
    logic [CW-1:0]        r_count;
    logic                 r_out_valid, r_out_end;
    logic [VW-1:0]        r_out_value;

    logic signed [VW-1:0] w_a;
    logic signed [AW-1:0] w_b_ext, w_step_ext;
    logic                 w_cond, w_out_free, w_emit;
    logic [VW-1:0]        w_emit_val, w_step32, w_bang_val, w_rewind_val;

    assign w_a        = i_cmd.src_prior ? r_prior : r_start;
    assign w_b_ext    = AW'(r_b);
    assign w_step_ext = AW'({1'b0, r_step});
    assign w_step32   = {1'b0, r_step};
    assign w_cond     = r_up ? (r_j < w_b_ext) : (r_j > w_b_ext);
    assign w_out_free = !r_out_valid || i_m_ready;
    assign w_emit     = i_cmd.emit_run || i_cmd.emit_tail;
    assign w_emit_val = i_cmd.emit_run ? r_j[VW-1:0] : r_b;

    // bang continues in the direction of the last two outputs, rewind steps back from start against it
    always_comb begin
        if (r_latest > r_prev) begin
            w_bang_val   = r_nc + w_step32;
            w_rewind_val = r_start - w_step32;
        end else if (r_latest < r_prev) begin
            w_bang_val   = r_nc - w_step32;
            w_rewind_val = r_start + w_step32;
        end else begin
            w_bang_val   = r_nc;
            w_rewind_val = r_start;
        end
    end

    assign o_st.list_open  = r_list_open;
    assign o_st.count_gt1  = (r_count > CW'(1));
    assign o_st.at_cap     = (r_count >= CW'(srg_pkg::MAX_RUN));
    assign o_st.run_go     = w_cond && !o_st.at_cap;
    assign o_st.eq_prior   = ($signed(i_operand) == r_prior);
    assign o_st.hold_valid = r_hold_valid;
    assign o_st.out_free   = w_out_free;

    assign o_m_valid = r_out_valid;
    assign o_m_value = r_out_value;
    assign o_m_end   = r_out_end;

    // payload registers: no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_b    <= $signed(i_operand);
            r_j    <= AW'(w_a);
            r_up   <= ($signed(i_operand) > w_a);
            r_mark <= i_cmd.mark;
        end else if (i_cmd.emit_run) begin
            r_j <= r_up ? (r_j + w_step_ext) : (r_j - w_step_ext);
        end
        if (w_emit) begin
            r_hold <= w_emit_val;
        end else if (i_cmd.bang) begin
            r_hold <= w_bang_val;
        end
        if (i_cmd.flush) begin
            r_out_value <= r_hold;
            r_out_end   <= r_mark;
        end else if (w_emit && r_hold_valid) begin
            r_out_value <= r_hold;
            r_out_end   <= 1'b0;
        end
    end

    // control and history state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start      <= '0;
            r_step       <= SW'(1);
            r_nc         <= '1;
            r_latest     <= '1;
            r_prev       <= -VW'(2);
            r_count      <= CW'(2);
            r_prior      <= '0;
            r_list_open  <= 1'b0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    srg_pkg::REG_START_VALUE: r_start <= $signed(i_cfg_wdata);
                    srg_pkg::REG_STEP_SIZE: begin
                        r_step <= (i_cfg_wdata[SW-1:0] == '0) ? SW'(1) : i_cfg_wdata[SW-1:0];
                    end
                    default: ;
                endcase
            end
            if (i_cmd.set_prior) begin
                r_prior <= $signed(i_operand);
            end
            if (i_cmd.list_clr) begin
                r_list_open <= 1'b0;
            end else if (i_cmd.list_set) begin
                r_list_open <= 1'b1;
            end

            // history: emits update everything, bang only r_nc; rewind sets r_nc or restores the history
            if (i_cmd.clr_count) begin
                r_count <= '0;
            end else if (w_emit) begin
                r_prev   <= r_latest;
                r_latest <= $signed(w_emit_val);
                r_nc     <= w_emit_val;
                r_count  <= r_count + CW'(1);
            end else if (i_cmd.bang) begin
                r_nc <= w_bang_val;
            end else if (i_cmd.rewind) begin
                if (o_st.count_gt1) begin
                    r_nc <= w_rewind_val;
                end else begin
                    r_prev   <= -VW'(2);
                    r_latest <= '1;
                    r_count  <= CW'(2);
                    r_nc     <= r_start - w_step32;
                end
            end

            if (w_emit || i_cmd.bang) begin
                r_hold_valid <= 1'b1;
            end else if (i_cmd.flush) begin
                r_hold_valid <= 1'b0;
            end

            if (i_cmd.flush || (w_emit && r_hold_valid)) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(srg_pkg::MAX_RUN))
        else $error("run count beyond cap");

    a_emit_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit || i_cmd.flush) && r_hold_valid |-> w_out_free)
        else $error("held result pushed over a stalled output");

    a_emit_below_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> $past(r_count) < CW'(srg_pkg::MAX_RUN))
        else $error("value emitted past run cap");

    a_bang_empty_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take |-> !r_hold_valid)
        else $error("item taken while a result is still held");

endmodule
